// ===== src/fdcd_pkg.sv =====
// Shared constants, codes and types for the frame difference change detector.
// No dependencies; used by fdcd_frame_store and frame_difference_change_detector.
`timescale 1ns / 1ps

package fdcd_pkg;

  localparam int MAX_FRAME_PIXELS = 131072;
  localparam int POS_W            = $clog2(MAX_FRAME_PIXELS);
  localparam int POS_CNT_W        = POS_W + 1;

  localparam int PIX_W   = 8;
  localparam int GRAY_W  = 8;
  localparam int TALLY_W = 18;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  localparam int WEIGHT_W   = 14;
  localparam int PROD_W     = 22;
  localparam int GRAY_SHIFT = 14;
  localparam logic [WEIGHT_W-1:0] W_RED   = 14'd4899;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 14'd9617;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 14'd1868;
  localparam logic [PROD_W-1:0]   ROUNDING = 22'd8192;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DIFF_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_CNT_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_LIMIT   = 2'd2;

  localparam logic [GRAY_W-1:0]  RST_PIXEL_DIFF_THR = 8'd30;
  localparam logic [TALLY_W-1:0] RST_CHANGE_CNT_THR = 18'd10240;
  localparam logic [7:0]         RST_STABLE_LIMIT   = 8'd10;

  typedef enum logic [STAT_W-1:0] {
    ST_REF_CAPTURED = 3'd0,
    ST_CHANGED      = 3'd1,
    ST_COUNTING     = 3'd2,
    ST_TRIGGER      = 3'd3,
    ST_AFTER        = 3'd4
  } status_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [POS_W-1:0]  pos;
    logic [GRAY_W-1:0] gray;
  } fdcd_wr_t;

endpackage

// ===== src/fdcd_frame_store.sv =====
// Two-bank gray frame store: one write and one read of both banks per cycle.
// Forwards a write that lands on the entry read at the same edge. Uses fdcd_pkg.
`timescale 1ns / 1ps

module fdcd_frame_store (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [fdcd_pkg::POS_W-1:0]       rd_pos,
  input  fdcd_pkg::fdcd_wr_t               wr,
  input  logic                             ref_bank,
  output logic [fdcd_pkg::GRAY_W-1:0]      ref_gray
);

  logic [fdcd_pkg::GRAY_W-1:0] bank0 [fdcd_pkg::MAX_FRAME_PIXELS];
  logic [fdcd_pkg::GRAY_W-1:0] bank1 [fdcd_pkg::MAX_FRAME_PIXELS];

  logic [fdcd_pkg::GRAY_W-1:0] rd0_r;
  logic [fdcd_pkg::GRAY_W-1:0] rd1_r;
  logic                        fwd_hit_r;
  logic                        fwd_bank_r;
  logic [fdcd_pkg::GRAY_W-1:0] fwd_gray_r;

  always_ff @(posedge clk) begin
    if (wr.en && !wr.bank) begin
      bank0[wr.pos] <= wr.gray;
    end
    if (rd_en) begin
      rd0_r <= bank0[rd_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.bank) begin
      bank1[wr.pos] <= wr.gray;
    end
    if (rd_en) begin
      rd1_r <= bank1[rd_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit_r  <= wr.en && (wr.pos == rd_pos);
      fwd_bank_r <= wr.bank;
      fwd_gray_r <= wr.gray;
    end
  end

  assign ref_gray = (fwd_hit_r && (fwd_bank_r == ref_bank)) ? fwd_gray_r :
                    (ref_bank ? rd1_r : rd0_r);

endmodule

// ===== src/frame_difference_change_detector.sv =====
// Top level: gray conversion, reference compare, frame tally and status output.
// Depends on fdcd_pkg and fdcd_frame_store.
//
//   channel  direction  beat
//   in_*     input      one BGR pixel plus last_pixel marker
//   out_*    output     one frame status at each last pixel
//   cfg_*    input      register write: index and data, no read-back
//
// One pixel per cycle sustained unless a held status stalls the pipeline; a frame's status is
// registered after its last pixel passes the stages: products, gray sum with store read, compare/tally/store write.
// Store read and write each use one port of the two-bank memory when their stage advances.
// Reset clears control state, configuration and valid flags; data registers and the frame store are not cleared.
// A held status stalls the pipeline only when the next last pixel reaches it.
`timescale 1ns / 1ps

module frame_difference_change_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fdcd_pkg::PIX_W-1:0]          in_blue,
  input  logic [fdcd_pkg::PIX_W-1:0]          in_green,
  input  logic [fdcd_pkg::PIX_W-1:0]          in_red,
  input  logic                                in_last_pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fdcd_pkg::STAT_W-1:0]         out_status,
  output logic [fdcd_pkg::TALLY_W-1:0]        out_changed_count,
  output logic                                out_frame_overflow,
  input  logic                                cfg_wr_en,
  input  logic [fdcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdcd_pkg::CFG_W-1:0]          cfg_wdata
);

  logic [fdcd_pkg::GRAY_W-1:0]  pix_thr_r;
  logic [fdcd_pkg::TALLY_W-1:0] cnt_thr_r;
  logic [7:0]                   limit_r;

  logic [fdcd_pkg::POS_CNT_W-1:0] pos_r;
  logic                           ovf_seen_r;
  logic                           have_ref_r;

  logic                          s1_valid_r;
  logic [fdcd_pkg::PROD_W-1:0]   s1_prod_r_r;
  logic [fdcd_pkg::PROD_W-1:0]   s1_prod_g_r;
  logic [fdcd_pkg::PROD_W-1:0]   s1_prod_b_r;
  logic [fdcd_pkg::POS_W-1:0]    s1_pos_r;
  logic                          s1_wr_r;
  logic                          s1_cmp_r;
  logic                          s1_first_r;
  logic                          s1_last_r;
  logic                          s1_ovf_r;

  logic                          s2_valid_r;
  logic [fdcd_pkg::GRAY_W-1:0]   s2_gray_r;
  logic [fdcd_pkg::POS_W-1:0]    s2_pos_r;
  logic                          s2_wr_r;
  logic                          s2_cmp_r;
  logic                          s2_first_r;
  logic                          s2_last_r;
  logic                          s2_ovf_r;

  logic                          ref_bank_r;
  logic [fdcd_pkg::TALLY_W-1:0]  tally_r;
  logic [7:0]                    stable_r;

  logic                          out_valid_r;
  fdcd_pkg::status_t             out_status_r;
  logic [fdcd_pkg::TALLY_W-1:0]  out_count_r;
  logic                          out_ovf_r;

  logic in_fire;
  logic in_range;
  logic out_free;
  logic s2_fire;
  logic s2_take;
  logic s1_move;
  logic s1_take;

  logic [fdcd_pkg::PROD_W-1:0]  gray_sum;
  logic [fdcd_pkg::GRAY_W-1:0]  s1_gray;
  logic [fdcd_pkg::GRAY_W-1:0]  ref_gray;
  logic [fdcd_pkg::GRAY_W-1:0]  abs_diff;
  logic                         changed;
  logic [fdcd_pkg::TALLY_W-1:0] tally_nxt;
  logic [7:0]                   stable_nxt;
  logic                         ref_bank_nxt;
  fdcd_pkg::status_t            status_nxt;
  logic [fdcd_pkg::TALLY_W-1:0] count_nxt;
  fdcd_pkg::fdcd_wr_t           store_wr;

  // handshake and stage advance
  assign out_free = !out_valid_r || out_ready;
  assign s2_fire  = s2_valid_r && (!s2_last_r || out_free);
  assign s2_take  = !s2_valid_r || s2_fire;
  assign s1_move  = s1_valid_r && s2_take;
  assign s1_take  = !s1_valid_r || s2_take;
  assign in_ready = s1_take;
  assign in_fire  = in_valid && in_ready;
  assign in_range = pos_r < fdcd_pkg::POS_CNT_W'(fdcd_pkg::MAX_FRAME_PIXELS);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_thr_r <= fdcd_pkg::RST_PIXEL_DIFF_THR;
      cnt_thr_r <= fdcd_pkg::RST_CHANGE_CNT_THR;
      limit_r   <= fdcd_pkg::RST_STABLE_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fdcd_pkg::CFG_PIXEL_DIFF_THR: pix_thr_r <= cfg_wdata[fdcd_pkg::GRAY_W-1:0];
        fdcd_pkg::CFG_CHANGE_CNT_THR: cnt_thr_r <= cfg_wdata[fdcd_pkg::TALLY_W-1:0];
        fdcd_pkg::CFG_STABLE_LIMIT:   limit_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // accept side: position, overflow, first-frame tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      ovf_seen_r <= 1'b0;
      have_ref_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_last_pixel) begin
          pos_r      <= '0;
          ovf_seen_r <= 1'b0;
          have_ref_r <= 1'b1;
        end else begin
          if (in_range) begin
            pos_r <= pos_r + fdcd_pkg::POS_CNT_W'(1);
          end
          ovf_seen_r <= ovf_seen_r || !in_range;
        end
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_prod_r_r <= fdcd_pkg::PROD_W'(in_red)   * fdcd_pkg::PROD_W'(fdcd_pkg::W_RED);
      s1_prod_g_r <= fdcd_pkg::PROD_W'(in_green) * fdcd_pkg::PROD_W'(fdcd_pkg::W_GREEN);
      s1_prod_b_r <= fdcd_pkg::PROD_W'(in_blue)  * fdcd_pkg::PROD_W'(fdcd_pkg::W_BLUE);
      s1_pos_r    <= pos_r[fdcd_pkg::POS_W-1:0];
      s1_wr_r     <= in_range;
      s1_cmp_r    <= have_ref_r && in_range;
      s1_first_r  <= !have_ref_r;
      s1_last_r   <= in_last_pixel;
      s1_ovf_r    <= ovf_seen_r || !in_range;
    end
  end

  // stage 1: gray sum, store read
  assign gray_sum = s1_prod_r_r + s1_prod_g_r + s1_prod_b_r + fdcd_pkg::ROUNDING;
  assign s1_gray  = gray_sum[fdcd_pkg::GRAY_SHIFT +: fdcd_pkg::GRAY_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_move) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_gray_r  <= s1_gray;
      s2_pos_r   <= s1_pos_r;
      s2_wr_r    <= s1_wr_r;
      s2_cmp_r   <= s1_cmp_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_ovf_r   <= s1_ovf_r;
    end
  end

  assign store_wr.en   = s2_fire && s2_wr_r;
  assign store_wr.bank = !ref_bank_r;
  assign store_wr.pos  = s2_pos_r;
  assign store_wr.gray = s2_gray_r;

  fdcd_frame_store u_store (
    .clk      (clk),
    .rd_en    (s1_move),
    .rd_pos   (s1_pos_r),
    .wr       (store_wr),
    .ref_bank (ref_bank_r),
    .ref_gray (ref_gray)
  );

  // stage 2: compare, tally, frame decision
  assign abs_diff  = (s2_gray_r > ref_gray) ? (s2_gray_r - ref_gray) : (ref_gray - s2_gray_r);
  assign changed   = s2_cmp_r && (abs_diff > pix_thr_r);
  assign tally_nxt = tally_r + fdcd_pkg::TALLY_W'(changed && (tally_r != fdcd_pkg::TALLY_MAX));

  always_comb begin
    stable_nxt   = stable_r;
    ref_bank_nxt = ref_bank_r;
    status_nxt   = fdcd_pkg::ST_REF_CAPTURED;
    count_nxt    = tally_nxt;
    if (s2_first_r) begin
      ref_bank_nxt = !ref_bank_r;
      count_nxt    = '0;
    end else if (tally_nxt >= cnt_thr_r) begin
      ref_bank_nxt = !ref_bank_r;
      stable_nxt   = '0;
      status_nxt   = fdcd_pkg::ST_CHANGED;
    end else if (stable_r < limit_r) begin
      stable_nxt = stable_r + 8'd1;
      status_nxt = ((stable_r + 8'd1) == limit_r) ? fdcd_pkg::ST_TRIGGER
                                                 : fdcd_pkg::ST_COUNTING;
    end else begin
      stable_nxt = (limit_r != 8'hFF) ? (limit_r + 8'd1) : 8'hFF;
      status_nxt = fdcd_pkg::ST_AFTER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_bank_r  <= 1'b0;
      tally_r     <= '0;
      stable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_fire) begin
        if (s2_last_r) begin
          tally_r    <= '0;
          ref_bank_r <= ref_bank_nxt;
          stable_r   <= stable_nxt;
        end else begin
          tally_r <= tally_nxt;
        end
      end
      if (s2_fire && s2_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_last_r) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_nxt;
      out_ovf_r    <= s2_ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_changed_count  = out_count_r;
  assign out_frame_overflow = out_ovf_r;

  a_ref_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == fdcd_pkg::ST_REF_CAPTURED)) |-> (out_count_r == '0))
    else $error("reference capture beat carries a nonzero count");

  a_bank_swap_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ref_bank_r != $past(ref_bank_r)) |-> $past(s2_fire && s2_last_r))
    else $error("reference bank swapped away from a frame end");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with an empty pipeline");

  a_status_from_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_last_r))
    else $error("status beat raised without a last pixel");

endmodule
